[src/crd_pkg.sv]
// Shared widths, character codes and result codes for the character reference decoder.
`default_nettype none

package crd_pkg;

  localparam int unsigned CHW = 16;
  localparam int unsigned LENW = 16;
  localparam int unsigned STW = 2;

  localparam logic [CHW-1:0] CH_SEMI = 16'h003B;
  localparam logic [CHW-1:0] CH_GT = 16'h003E;
  localparam logic [CHW-1:0] CH_HASH = 16'h0023;
  localparam logic [CHW-1:0] CH_LX = 16'h0078;
  localparam logic [CHW-1:0] CH_UX = 16'h0058;
  localparam logic [LENW-1:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [STW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NAMED   = 2'd2,
    ST_UNTERM  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_HASH   = 2'd1,
    POS_DIGITS = 2'd2,
    POS_NAMED  = 2'd3
  } pos_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DEC  = 2'd1,
    KIND_HEX  = 2'd2
  } kind_e;

endpackage

`default_nettype wire

[src/crd_if.sv]
// Stream interfaces for code units in and decoded references out.
`default_nettype none

interface crd_in_if;
  logic                    valid;
  logic                    ready;
  logic [crd_pkg::CHW-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface crd_out_if;
  logic                     valid;
  logic                     ready;
  logic [crd_pkg::STW-1:0]  status;
  logic [crd_pkg::CHW-1:0]  code_point;
  logic [crd_pkg::LENW-1:0] name_length;

  modport source (output valid, output status, output code_point, output name_length,
                  input ready);
  modport sink (input valid, input status, input code_point, input name_length,
                output ready);
endinterface

`default_nettype wire

[src/char_reference_decoder.sv]
// Numeric character reference decoder: one code unit per beat, one result per reference.
//
//  channel | dir | payload                          | beat when
//  in_i    | in  | ch                               | valid && ready
//  out_o   | out | status, code_point, name_length  | valid && ready
//
// One code unit is taken every cycle that in_i.ready is high; a ';' or '>'
// beat yields its result on the next cycle from the output register. The
// accumulator step (x10/x16 plus digit, then a range compare) is combinational.
// Reset clears all reference state and empties the output register.
// in_i.ready drops only while a result waits and out_o.ready is low.
`default_nettype none

module char_reference_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  crd_in_if.sink    in_i,
  crd_out_if.source out_o
);
  import crd_pkg::*;

  pos_e            pos_q, pos_d;
  kind_e           kind_q, kind_d;
  logic [CHW-1:0]  acc_q, acc_d;
  logic            seen_q, seen_d;
  logic            bad_q, bad_d;
  logic [LENW-1:0] cnt_q, cnt_d;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [CHW-1:0]  cp_q, cp_d;
  logic [LENW-1:0] len_q, len_d;

  logic            in_acc;
  logic            term;
  logic            is_hex;
  logic            dig_ok;
  logic [3:0]      dig_val;
  logic [CHW+4:0]  next_val;
  logic            take_dig;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc = in_i.valid && in_i.ready;
  assign term = (in_i.ch == CH_SEMI) || (in_i.ch == CH_GT);
  assign is_hex = (kind_q == KIND_HEX);

  always_comb begin
    dig_ok = 1'b0;
    dig_val = 4'd0;
    if (in_i.ch >= 16'h0030 && in_i.ch <= 16'h0039) begin
      dig_ok = 1'b1;
      dig_val = in_i.ch[3:0];
    end else if (is_hex && in_i.ch >= 16'h0041 && in_i.ch <= 16'h0046) begin
      dig_ok = 1'b1;
      dig_val = 4'(in_i.ch[3:0] + 4'd9);
    end else if (is_hex && in_i.ch >= 16'h0061 && in_i.ch <= 16'h0066) begin
      dig_ok = 1'b1;
      dig_val = 4'(in_i.ch[3:0] + 4'd9);
    end
  end

  // x16 is a shift; x10 is x8 + x2
  always_comb begin
    if (is_hex) begin
      next_val = {1'b0, acc_q, 4'd0} + {17'd0, dig_val};
    end else begin
      next_val = {2'b0, acc_q, 3'd0} + {4'b0, acc_q, 1'b0} + {17'd0, dig_val};
    end
  end

  always_comb begin
    pos_d = pos_q;
    kind_d = kind_q;
    acc_d = acc_q;
    seen_d = seen_q;
    bad_d = bad_q;
    cnt_d = cnt_q;
    take_dig = 1'b0;

    out_valid_d = out_valid_q && !out_o.ready;
    status_d = status_q;
    cp_d = cp_q;
    len_d = len_q;

    if (in_acc) begin
      if (term) begin
        out_valid_d = 1'b1;
        cp_d = '0;
        len_d = cnt_q;
        if (in_i.ch == CH_GT) begin
          status_d = ST_UNTERM;
        end else if (kind_q == KIND_NONE) begin
          status_d = ST_NAMED;
        end else if (seen_q && !bad_q) begin
          status_d = ST_OK;
          cp_d = acc_q;
        end else begin
          status_d = ST_INVALID;
        end
        pos_d = POS_FIRST;
        kind_d = KIND_NONE;
        acc_d = '0;
        seen_d = 1'b0;
        bad_d = 1'b0;
        cnt_d = '0;
      end else begin
        if (cnt_q != LEN_MAX) begin
          cnt_d = cnt_q + 1'b1;
        end
        case (pos_q)
          POS_FIRST: begin
            if (in_i.ch == CH_HASH) begin
              kind_d = KIND_DEC;
              pos_d = POS_HASH;
            end else begin
              pos_d = POS_NAMED;
            end
          end
          POS_HASH: begin
            pos_d = POS_DIGITS;
            if (in_i.ch == CH_LX || in_i.ch == CH_UX) begin
              kind_d = KIND_HEX;
            end else begin
              take_dig = 1'b1;
            end
          end
          POS_DIGITS: take_dig = 1'b1;
          default: ;
        endcase
        if (take_dig) begin
          if (!dig_ok) begin
            bad_d = 1'b1;
          end else begin
            seen_d = 1'b1;
            // once bad, the value stays frozen
            if (!bad_q) begin
              if (next_val[CHW+4:CHW] != '0) begin
                bad_d = 1'b1;
              end else begin
                acc_d = next_val[CHW-1:0];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_FIRST;
      kind_q <= KIND_NONE;
      acc_q <= '0;
      seen_q <= 1'b0;
      bad_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      kind_q <= kind_d;
      acc_q <= acc_d;
      seen_q <= seen_d;
      bad_q <= bad_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    cp_q <= cp_d;
    len_q <= len_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.status = status_q;
  assign out_o.code_point = cp_q;
  assign out_o.name_length = len_q;

  a_term_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && term |=> out_valid_q)
    else $error("terminator beat did not load a result");

  a_term_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && term |=> pos_q == POS_FIRST && kind_q == KIND_NONE && cnt_q == '0
                       && !bad_q && !seen_q)
    else $error("reference state not cleared after terminator");

  a_cp_only_when_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> cp_q == '0)
    else $error("code point set on a non-numeric or invalid result");

  a_bad_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_q && in_acc && !term |=> bad_q)
    else $error("bad flag dropped inside a reference");

endmodule

`default_nettype wire

[tb/sv/tb_char_reference_decoder.sv]
// Self-checking testbench for the character reference decoder: directed and random references.
`timescale 1ns / 1ps

module tb_char_reference_decoder;
  import crd_pkg::*;

  localparam int unsigned RANDOM_UNITS = 430;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    status_e         status;
    logic [CHW-1:0]  code_point;
    logic [LENW-1:0] name_length;
  } ref_result_t;

  // Tracks the decoder state per beat and keeps the decoded references still owed.
  class crd_result_board;
    pos_e            pos;
    kind_e           kind;
    logic [CHW-1:0]  acc;
    bit              seen_digit;
    bit              bad;
    logic [LENW-1:0] units;
    ref_result_t     owed_refs[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     status_count[4];

    function new();
      clear_ref();
      errors  = 0;
      checked = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void clear_ref();
      pos        = POS_FIRST;
      kind       = KIND_NONE;
      acc        = '0;
      seen_digit = 1'b0;
      bad        = 1'b0;
      units      = '0;
    endfunction

    // 16 marks a unit that is no digit of the current base
    function int unsigned digit_of(logic [CHW-1:0] c);
      if (c >= 16'h0030 && c <= 16'h0039) return c - 16'h0030;
      if (kind == KIND_HEX) begin
        if (c >= 16'h0041 && c <= 16'h0046) return c - 16'h0041 + 10;
        if (c >= 16'h0061 && c <= 16'h0066) return c - 16'h0061 + 10;
      end
      return 16;
    endfunction

    function void take_digit(logic [CHW-1:0] c);
      int unsigned base;
      int unsigned d;
      int unsigned nxt;
      base = (kind == KIND_HEX) ? 16 : 10;
      d    = digit_of(c);
      if (d >= base) begin
        bad = 1'b1;
        return;
      end
      seen_digit = 1'b1;
      if (bad) return;
      nxt = acc * base + d;
      // over range is sticky and freezes the accumulator
      if (nxt > 32'h0000_FFFF) bad = 1'b1;
      else acc = nxt[CHW-1:0];
    endfunction

    function void note_unit(logic [CHW-1:0] c);
      ref_result_t r;
      if (c == CH_SEMI || c == CH_GT) begin
        r.code_point  = '0;
        r.name_length = units;
        if (c == CH_GT) r.status = ST_UNTERM;
        else if (kind == KIND_NONE) r.status = ST_NAMED;
        else if (seen_digit && !bad) begin
          r.status     = ST_OK;
          r.code_point = acc;
        end else r.status = ST_INVALID;
        owed_refs.push_back(r);
        clear_ref();
        return;
      end
      if (units != LEN_MAX) units++;
      case (pos)
        POS_FIRST: begin
          if (c == CH_HASH) begin
            kind = KIND_DEC;
            pos  = POS_HASH;
          end else pos = POS_NAMED;
        end
        POS_HASH: begin
          pos = POS_DIGITS;
          if (c == CH_LX || c == CH_UX) kind = KIND_HEX;
          else take_digit(c);
        end
        POS_DIGITS: take_digit(c);
        default: ;
      endcase
    endfunction

    function void check_result(logic [STW-1:0] st, logic [CHW-1:0] cp, logic [LENW-1:0] len);
      ref_result_t e;
      if (owed_refs.size() == 0) begin
        $display("%0t: result with none owed: status %0d code_point %h name_length %0d",
                 $time, st, cp, len);
        errors++;
        return;
      end
      e = owed_refs.pop_front();
      checked++;
      status_count[e.status]++;
      if (st !== e.status || cp !== e.code_point || len !== e.name_length) begin
        $display({"%0t: mismatch: expected status %0d code_point %h name_length %0d,",
                  " got %0d %h %0d"},
                 $time, e.status, e.code_point, e.name_length, st, cp, len);
        errors++;
      end
    endfunction

    function int pending();
      return owed_refs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  crd_in_if  code_in ();
  crd_out_if ref_out ();

  char_reference_decoder i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (code_in),
    .out_o (ref_out)
  );

  crd_result_board board = new();
  int unsigned     units_sent = 0;
  bit              hold_done = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHW-1:0] rand_unit();
    logic [CHW-1:0] c;
    c = CHW'($urandom_range(0, 65535));
    while (c == CH_SEMI || c == CH_GT) c = CHW'($urandom_range(0, 65535));
    return c;
  endfunction

  function automatic logic [CHW-1:0] hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CHW'(16'h0030 + r);
    if (r < 16) return CHW'(16'h0041 + r - 10);
    return CHW'(16'h0061 + r - 16);
  endfunction

  function automatic logic [CHW-1:0] dec_digit();
    return CHW'(16'h0030 + $urandom_range(0, 9));
  endfunction

  task automatic drive_unit(input logic [CHW-1:0] c, input bit use_gaps);
    int gap;
    gap = use_gaps ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      code_in.valid <= 1'b0;
    end
    @(negedge clk);
    code_in.valid <= 1'b1;
    code_in.ch    <= c;
    @(posedge clk);
    while (!code_in.ready) @(posedge clk);
    board.note_unit(c);
    units_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) drive_unit({8'h00, s[i]}, 1'b1);
  endtask

  task automatic send_random_ref(output int n_units);
    logic [CHW-1:0] unit_q[$];
    int             r;
    int             n;
    int             bad_at;
    int unsigned    v;
    bit             hex;
    bit             gaps;
    string          txt;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      unit_q.push_back(CH_HASH);
      if ($urandom_range(0, 9) == 0) begin
        v   = $urandom_range(65530, 65540);
        txt = $sformatf("%0d", v);
        foreach (txt[i]) unit_q.push_back({8'h00, txt[i]});
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) unit_q.push_back(dec_digit());
      end
    end else if (r < 75) begin
      unit_q.push_back(CH_HASH);
      unit_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      if ($urandom_range(0, 9) == 0) begin
        v   = $urandom_range(32'h0000_FFF0, 32'h0001_000F);
        txt = $sformatf("%0h", v);
        if ($urandom_range(0, 1)) txt = txt.toupper();
        foreach (txt[i]) unit_q.push_back({8'h00, txt[i]});
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) unit_q.push_back(hex_digit());
      end
    end else if (r < 88) begin
      unit_q.push_back(rand_unit());
      while (unit_q[0] == CH_HASH) unit_q[0] = rand_unit();
      n = $urandom_range(0, 5);
      repeat (n) unit_q.push_back(rand_unit());
    end else begin
      // mostly broken numeric reference: one unit that is usually not a digit of the base
      hex = $urandom_range(0, 1);
      unit_q.push_back(CH_HASH);
      if (hex) unit_q.push_back(CH_LX);
      n      = $urandom_range(0, 4);
      bad_at = $urandom_range(0, n);
      for (int k = 0; k <= n; k++) begin
        if (k == bad_at) begin
          case ($urandom_range(0, 4))
            0: unit_q.push_back(CHW'(0));
            1: unit_q.push_back(CH_LX);
            2: unit_q.push_back(CHW'(16'h0067));
            3: unit_q.push_back(CH_HASH);
            default: unit_q.push_back(rand_unit());
          endcase
        end
        if (k < n) unit_q.push_back(hex ? hex_digit() : dec_digit());
      end
    end
    unit_q.push_back(($urandom_range(0, 99) < 85) ? CH_SEMI : CH_GT);
    gaps = ($urandom_range(0, 3) != 0);
    foreach (unit_q[i]) drive_unit(unit_q[i], gaps);
    n_units = unit_q.size();
  endtask

  always @(posedge clk) begin
    if (rst_n && ref_out.valid && ref_out.ready)
      board.check_result(ref_out.status, ref_out.code_point, ref_out.name_length);
  end

  initial begin
    int run;
    int gap;
    ref_out.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && board.checked >= 40) begin
        hold_done = 1'b1;
        @(negedge clk);
        ref_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      run = $urandom_range(1, 30);
      repeat (run) begin
        @(negedge clk);
        ref_out.ready <= 1'b1;
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk);
        ref_out.ready <= 1'b0;
      end
    end
  end

  initial begin
    #1_500_000;
    $display("tb_char_reference_decoder: errors");
    $finish;
  end

  initial begin
    int unsigned random_units;
    int          n;
    random_units  = 0;
    rst_n         = 1'b0;
    code_in.valid = 1'b0;
    code_in.ch    = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text(";");
    send_text("#;");
    send_text("#x;");
    send_text("#0;");
    send_text("#X10000;");
    send_text("#1a>");
    drive_unit(CHW'(16'hFFFF), 1'b1);
    drive_unit(CHW'(0), 1'b1);
    drive_unit(CH_SEMI, 1'b1);

    while (random_units < RANDOM_UNITS) begin
      send_random_ref(n);
      random_units += n;
    end
    @(negedge clk);
    code_in.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run: %0d code units in, %0d references checked.", units_sent, board.checked);
    $display("Results: %0d ok, %0d invalid, %0d named, %0d unterminated; held for %0d cycles.",
             board.status_count[ST_OK], board.status_count[ST_INVALID],
             board.status_count[ST_NAMED], board.status_count[ST_UNTERM], HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("tb_char_reference_decoder: clean");
    end else begin
      $display("tb_char_reference_decoder: errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/crd_pkg.sv
src/crd_if.sv
src/char_reference_decoder.sv
tb/sv/tb_char_reference_decoder.sv
